### src/forro_pkg.sv
// Shared types, constants and quarter-step helpers for the Forro stream cipher.
// Has no dependencies; the front, back and top level modules use it.
package forro_pkg;

	localparam int ROUNDS = 7;
	localparam int WORDS = 16;
	localparam int STEPS = ROUNDS * 8;
	localparam int STEP_W = $clog2(STEPS + 1);

	localparam logic [2:0] CFG_KEY_LOW_A  = 3'd0;
	localparam logic [2:0] CFG_KEY_LOW_B  = 3'd1;
	localparam logic [2:0] CFG_KEY_HIGH_A = 3'd2;
	localparam logic [2:0] CFG_KEY_HIGH_B = 3'd3;
	localparam logic [2:0] CFG_NONCE      = 3'd4;
	localparam logic [2:0] CFG_PREPERMUTE = 3'd5;

	localparam logic [31:0] SIGMA6  = 32'h61707865;
	localparam logic [31:0] SIGMA7  = 32'h3320646e;
	localparam logic [31:0] SIGMA14 = 32'h79622d32;
	localparam logic [31:0] SIGMA15 = 32'h6b206574;

	typedef logic [31:0] word_t;
	typedef word_t [WORDS-1:0] state_t;

	// Classified item as it travels from front to back.
	typedef struct packed {
		logic        restart;
		logic [31:0] msg_word;
		logic [2:0]  nbytes;
		logic        last;
	} item_t;

	// Result item.
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
	} res_t;

	// Word indexes a, b, c, d, e of quarter-step q (0..7) of a round.
	function automatic logic [19:0] qidx(input logic [2:0] q);
		logic [3:0] a, b, c, d, e;
		a = {2'b00, q[1:0]};
		b = q[2] ? {2'b01, q[1:0] + 2'd1} : {2'b01, q[1:0]};
		c = q[2] ? {2'b10, q[1:0] + 2'd2} : {2'b10, q[1:0]};
		d = q[2] ? {2'b11, q[1:0] + 2'd3} : {2'b11, q[1:0]};
		e = {2'b00, q[1:0] - 2'd1};
		return {a, b, c, d, e};
	endfunction

	function automatic word_t rotl(input word_t v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// One ARX quarter-step on five words.
	function automatic state_t quarter(input state_t s, input logic [2:0] q);
		logic [19:0] ix;
		word_t a, b, c, d, e;
		state_t r;
		ix = qidx(q);
		a = s[ix[19:16]]; b = s[ix[15:12]]; c = s[ix[11:8]];
		d = s[ix[7:4]]; e = s[ix[3:0]];
		d = d + e; c = c ^ d; b = b + c; b = rotl(b, 10);
		a = a + b; e = e ^ a; d = d + e; d = rotl(d, 27);
		c = c + d; b = b ^ c; a = a + b; a = rotl(a, 8);
		r = s;
		r[ix[19:16]] = a; r[ix[15:12]] = b; r[ix[11:8]] = c;
		r[ix[7:4]] = d; r[ix[3:0]] = e;
		return r;
	endfunction

endpackage

### src/forro_front.sv
// Front part: accepts input items, saturates the byte count and keeps a
// two-entry queue towards the back part. Depends on forro_pkg.
module forro_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 restart,
	input  logic [31:0]          msg_word,
	input  logic [2:0]           valid_bytes,
	input  logic                 last_word,
	output logic                 q_valid,
	input  logic                 q_ready,
	output forro_pkg::item_t     q_item
);

	forro_pkg::item_t mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	forro_pkg::item_t it;
	logic             push, pop;

	// Classify the byte count.
	always_comb begin
		it.restart = restart;
		it.msg_word = msg_word;
		it.last = last_word;
		priority if (valid_bytes == 3'd0) it.nbytes = 3'd1;
		else if (valid_bytes > 3'd4) it.nbytes = 3'd4;
		else it.nbytes = valid_bytes;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= it;
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	ap_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !in_ready) else $error("ready while full");
	ap_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !q_valid) else $error("valid while empty");

endmodule

### src/forro_back.sv
// Back part: keeps the cipher state, makes keystream blocks one quarter-step
// a cycle and encrypts queued items. Depends on forro_pkg.
module forro_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [63:0]          key_low_a,
	input  logic [63:0]          key_low_b,
	input  logic [63:0]          key_high_a,
	input  logic [63:0]          key_high_b,
	input  logic [63:0]          nonce,
	input  logic                 prepermute,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  forro_pkg::item_t     q_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output forro_pkg::res_t      out_res
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PRE  = 4'b0010,
		ST_GEN  = 4'b0100,
		ST_EMIT = 4'b1000
	} st_t;

	st_t                           st_q;
	forro_pkg::state_t             cs_q, work_q;
	forro_pkg::word_t              ks_q [forro_pkg::WORDS];
	logic [3:0]                    pos_q;
	logic                          bv_q;
	logic [forro_pkg::STEP_W-1:0]  step_q;
	logic [2:0]                    qs_q;
	forro_pkg::item_t              cur_q;
	logic                          ov_q;
	forro_pkg::res_t               res_q;
	forro_pkg::state_t             fresh, qnext;
	forro_pkg::word_t              mask;
	logic                          done;

	// Freshly loaded state from the registers.
	always_comb begin
		fresh[0] = key_low_a[31:0];  fresh[1] = key_low_a[63:32];
		fresh[2] = key_low_b[31:0];  fresh[3] = key_low_b[63:32];
		fresh[4] = '0;               fresh[5] = '0;
		fresh[6] = forro_pkg::SIGMA6; fresh[7] = forro_pkg::SIGMA7;
		fresh[8] = key_high_a[31:0]; fresh[9] = key_high_a[63:32];
		fresh[10] = key_high_b[31:0]; fresh[11] = key_high_b[63:32];
		fresh[12] = nonce[31:0];     fresh[13] = nonce[63:32];
		fresh[14] = forro_pkg::SIGMA14; fresh[15] = forro_pkg::SIGMA15;
	end

	assign qnext = forro_pkg::quarter(work_q, qs_q);
	assign done = (step_q == forro_pkg::STEP_W'(forro_pkg::STEPS - 1));
	assign q_ready = (st_q == ST_IDLE);
	assign out_valid = ov_q;
	assign out_res = res_q;

	always_comb begin
		unique case (cur_q.nbytes)
			3'd1: mask = 32'h000000ff;
			3'd2: mask = 32'h0000ffff;
			3'd3: mask = 32'h00ffffff;
			default: mask = 32'hffffffff;
		endcase
	end

	// Keystream store, current item and result register.
	always_ff @(posedge clk) begin
		if (st_q == ST_GEN && done) begin
			for (int i = 0; i < forro_pkg::WORDS; i++) ks_q[i] <= qnext[i] + cs_q[i];
		end
		if (q_valid && q_ready) cur_q <= q_item;
		if (st_q == ST_EMIT && !ov_q) begin
			res_q.word <= (cur_q.msg_word ^ ks_q[pos_q]) & mask;
			res_q.nbytes <= cur_q.nbytes;
			res_q.last <= cur_q.last;
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cs_q <= '0;
			work_q <= '0;
			pos_q <= '0;
			bv_q <= 1'b0;
			step_q <= '0;
			qs_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						step_q <= '0;
						qs_q <= '0;
						if (q_item.restart) begin
							cs_q <= fresh;
							work_q <= fresh;
							pos_q <= '0;
							bv_q <= 1'b0;
							st_q <= prepermute ? ST_PRE : ST_GEN;
						end else begin
							work_q <= cs_q;
							st_q <= bv_q ? ST_EMIT : ST_GEN;
						end
					end
				end
				ST_PRE: begin
					work_q <= qnext;
					qs_q <= qs_q + 3'd1;
					step_q <= step_q + 1'b1;
					if (done) begin
						cs_q <= qnext;
						work_q <= qnext;
						step_q <= '0;
						qs_q <= '0;
						st_q <= ST_GEN;
					end
				end
				ST_GEN: begin
					work_q <= qnext;
					qs_q <= qs_q + 3'd1;
					step_q <= step_q + 1'b1;
					if (done) begin
						cs_q[4] <= cs_q[4] + 32'd1;
						if (cs_q[4] == 32'hffffffff) cs_q[5] <= cs_q[5] + 32'd1;
						pos_q <= '0;
						bv_q <= 1'b1;
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!ov_q) begin
						ov_q <= 1'b1;
						pos_q <= cur_q.last ? 4'd0 : pos_q + 4'd1;
						if (cur_q.last || pos_q == 4'd15) bv_q <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	ap_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT && !ov_q) |=> ov_q) else $error("result not shown");
	ap_bv: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_GEN && done) |=> bv_q && pos_q == 4'd0) else $error("block not live");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> ov_q && $stable(res_q)) else $error("result lost");

endmodule

### src/forro_stream_cipher_core.sv
// Top level of the Forro stream cipher: configuration registers, front and back.
// Depends on forro_pkg, forro_front and forro_back.
//
//  channel   direction  handshake                     payload
//  in        input      in_valid / in_ready           restart msg_word valid_bytes last_word
//  out       output     out_valid / out_ready         out_word out_bytes out_last
//  cfg       input      cfg_we                        cfg_index cfg_data
//
// A word that uses a live block passes the back part through the idle state, which takes it
// from the queue, and the emit state, which encrypts it into the output register. A word
// that needs a new block first passes the generate state (one quarter-step a cycle), and
// also the pre-permute state on a restart in absorb mode. Reset is asynchronous and clears
// all control state. The input side stalls only when the two-entry queue is full;
// the output register holds a result until it is taken.
module forro_stream_cipher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        restart,
	input  logic [31:0] msg_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_word,
	output logic [2:0]  out_bytes,
	output logic        out_last
);

	logic [63:0]       kla_q, klb_q, kha_q, khb_q, nonce_q;
	logic              pre_q;
	logic              q_valid, q_ready;
	forro_pkg::item_t  q_item;
	forro_pkg::res_t   res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kla_q <= '0; klb_q <= '0; kha_q <= '0; khb_q <= '0;
			nonce_q <= '0; pre_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				forro_pkg::CFG_KEY_LOW_A:  kla_q <= cfg_data;
				forro_pkg::CFG_KEY_LOW_B:  klb_q <= cfg_data;
				forro_pkg::CFG_KEY_HIGH_A: kha_q <= cfg_data;
				forro_pkg::CFG_KEY_HIGH_B: khb_q <= cfg_data;
				forro_pkg::CFG_NONCE:      nonce_q <= cfg_data;
				forro_pkg::CFG_PREPERMUTE: pre_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	forro_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .restart, .msg_word, .valid_bytes,
		.last_word, .q_valid, .q_ready, .q_item
	);

	forro_back u_back (
		.clk, .arst_n, .key_low_a(kla_q), .key_low_b(klb_q), .key_high_a(kha_q),
		.key_high_b(khb_q), .nonce(nonce_q), .prepermute(pre_q),
		.q_valid, .q_ready, .q_item, .out_valid, .out_ready, .out_res(res)
	);

	assign out_word = res.word;
	assign out_bytes = res.nbytes;
	assign out_last = res.last;

endmodule

### verif/forro_checker.sv
// Checker for the Forro stream cipher core: predicts each result item and compares it.
// Depends on forro_pkg; watches the configuration, input and output channels.
module forro_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        restart,
	input  logic [31:0] msg_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_word,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] out_word,
	input  logic [2:0]  out_bytes,
	input  logic        out_last,
	output int          fail_count,
	output int          pending
);
	import forro_pkg::*;

	typedef logic [31:0] w32_t;
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
	} cipher_out_t;

	// Shadow of the configuration and of the cipher state.
	logic [63:0] key_la, key_lb, key_ha, key_hb, nonce_reg;
	logic        absorb;
	w32_t        st [16];
	w32_t        ks [16];
	int          pos;
	logic        have_block;
	cipher_out_t expected_words[$];

	function automatic w32_t rol(input w32_t v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	task automatic qstep(inout w32_t s[16], input int a, input int b, input int c,
		input int d, input int e);
		s[d] += s[e]; s[c] ^= s[d]; s[b] += s[c]; s[b] = rol(s[b], 10);
		s[a] += s[b]; s[e] ^= s[a]; s[d] += s[e]; s[d] = rol(s[d], 27);
		s[c] += s[d]; s[b] ^= s[c]; s[a] += s[b]; s[a] = rol(s[a], 8);
	endtask

	task automatic scramble(inout w32_t s[16]);
		for (int r = 0; r < ROUNDS; r++) begin
			qstep(s, 0, 4, 8, 12, 3);
			qstep(s, 1, 5, 9, 13, 0);
			qstep(s, 2, 6, 10, 14, 1);
			qstep(s, 3, 7, 11, 15, 2);
			qstep(s, 0, 5, 10, 15, 3);
			qstep(s, 1, 6, 11, 12, 0);
			qstep(s, 2, 7, 8, 13, 1);
			qstep(s, 3, 4, 9, 14, 2);
		end
	endtask

	// Works out the ciphertext word for one accepted item.
	task automatic encrypt_word(input logic rs, input w32_t m, input logic [2:0] vb,
		input logic lst);
		w32_t work[16];
		w32_t mask;
		int n;
		cipher_out_t r;
		n = (vb == 0) ? 1 : ((vb > 4) ? 4 : vb);
		if (rs) begin
			st[0] = key_la[31:0]; st[1] = key_la[63:32];
			st[2] = key_lb[31:0]; st[3] = key_lb[63:32];
			st[4] = '0; st[5] = '0; st[6] = SIGMA6; st[7] = SIGMA7;
			st[8] = key_ha[31:0]; st[9] = key_ha[63:32];
			st[10] = key_hb[31:0]; st[11] = key_hb[63:32];
			st[12] = nonce_reg[31:0]; st[13] = nonce_reg[63:32];
			st[14] = SIGMA14; st[15] = SIGMA15;
			if (absorb) scramble(st);
			have_block = 1'b0;
			pos = 0;
		end
		if (!have_block) begin
			work = st;
			scramble(work);
			for (int i = 0; i < 16; i++) ks[i] = work[i] + st[i];
			st[4] += 1;
			if (st[4] == 0) st[5] += 1;
			pos = 0;
			have_block = 1'b1;
		end
		mask = (n == 4) ? 32'hffffffff : ((32'd1 << (8 * n)) - 1);
		r.word = (m ^ ks[pos]) & mask;
		r.nbytes = 3'(n);
		r.last = lst;
		pos = (pos + 1) % 16;
		if (pos == 0) have_block = 1'b0;
		if (lst) begin
			have_block = 1'b0;
			pos = 0;
		end
		expected_words.push_back(r);
	endtask

	assign pending = expected_words.size();

	// Watch all channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		cipher_out_t e;
		if (!arst_n) begin
			key_la = '0; key_lb = '0; key_ha = '0; key_hb = '0; nonce_reg = '0;
			absorb = 1'b0;
			for (int i = 0; i < 16; i++) begin
				st[i] = '0;
				ks[i] = '0;
			end
			pos = 0;
			have_block = 1'b0;
			fail_count = 0;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_LOW_A:  key_la = cfg_data;
					CFG_KEY_LOW_B:  key_lb = cfg_data;
					CFG_KEY_HIGH_A: key_ha = cfg_data;
					CFG_KEY_HIGH_B: key_hb = cfg_data;
					CFG_NONCE:      nonce_reg = cfg_data;
					CFG_PREPERMUTE: absorb = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				encrypt_word(restart, msg_word, valid_bytes, last_word);
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected item: word %h bytes %0d last %0b",
							out_word, out_bytes, out_last);
				end else begin
					e = expected_words.pop_front();
					if (e.word !== out_word || e.nbytes !== out_bytes ||
						e.last !== out_last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("item mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
								e.word, e.nbytes, e.last, out_word, out_bytes, out_last);
					end
				end
			end
		end
	end
endmodule

### verif/testbench.sv
// Stimulus and verdict for the Forro stream cipher core.
// Depends on forro_pkg, forro_stream_cipher_core and forro_checker.
module testbench;
	import forro_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = CFG_KEY_LOW_A;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        restart = 1'b0;
	logic [31:0] msg_word = '0;
	logic [2:0]  valid_bytes = 3'd4;
	logic        last_word = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] out_word;
	logic [2:0]  out_bytes;
	logic        out_last;
	int          fail_count;
	int          pending;
	int          send_idle = 0;
	int          recv_idle = 0;
	int          quiet_cycles = 0;

	always #2 clk = ~clk;

	forro_stream_cipher_core u_dut (.*);

	forro_checker u_checker (.*);

	// Receiver: stall at the current rate.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle);

	// Watchdog on cycles with no accepted item; the clearing of an absorb restart fits easily.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every expected item has come back, then lets the core settle.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Sends one item, with a random gap ahead of it; valid drops only in the gap.
	task automatic send_word(input logic rs, input logic [31:0] m, input logic [2:0] vb,
		input logic lst);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rs;
		msg_word <= m;
		valid_bytes <= vb;
		last_word <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64(input int kind);
		case (kind)
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic program_all(input int kind, input logic pp);
		write_reg(CFG_KEY_LOW_A, rand64(kind));
		write_reg(CFG_KEY_LOW_B, rand64(kind));
		write_reg(CFG_KEY_HIGH_A, rand64(kind));
		write_reg(CFG_KEY_HIGH_B, rand64(kind));
		write_reg(CFG_NONCE, rand64(kind));
		write_reg(CFG_PREPERMUTE, {63'd0, pp});
	endtask

	// One message: a restart, full words, and a possibly short last word.
	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_word(i == 0, $urandom, (i == len - 1) ? 3'($urandom_range(1, 4)) : 3'd4,
				i == len - 1);
	endtask

	initial begin
		int count;
		int len;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: words before any restart, then extremes of every field.
		send_word(1'b0, 32'h0, 3'd4, 1'b0);
		send_word(1'b0, 32'hffffffff, 3'd0, 1'b0);
		send_word(1'b0, 32'hffffffff, 3'd7, 1'b1);
		drain();
		program_all(1, 1'b0);
		send_word(1'b1, 32'hffffffff, 3'd5, 1'b0);
		send_word(1'b0, 32'ha5a5a5a5, 3'd2, 1'b0);
		send_word(1'b0, 32'h5a5a5a5a, 3'd3, 1'b0);
		for (int i = 0; i < 15; i++)
			send_word(1'b0, $urandom, 3'd4, 1'b0);
		send_word(1'b0, 32'h12345678, 3'd6, 1'b1);
		drain();
		program_all(2, 1'b1);
		send_word(1'b1, 32'h0, 3'd1, 1'b1);
		send_word(1'b1, 32'hffffffff, 3'd4, 1'b0);
		drain();
		// Random phases over three idling patterns and several settings.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 37 : ((ph == 1) ? 46 : 0);
			recv_idle = (ph == 0) ? 46 : ((ph == 1) ? 37 : 0);
			for (int cf = 0; cf < 2; cf++) begin
				program_all((ph == 2 && cf == 0) ? 0 : 2, 1'($urandom_range(1)));
				count = 0;
				while (count < 100) begin
					if ($urandom_range(9) < 8) begin
						len = $urandom_range(1, 40);
						send_message(len);
						count += len;
					end else begin
						send_word(1'($urandom_range(1)), $urandom, 3'($urandom_range(7)),
							1'($urandom_range(1)));
						count++;
					end
				end
				drain();
			end
		end
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

### forro_stream_cipher_core.f
src/forro_pkg.sv
src/forro_front.sv
src/forro_back.sv
src/forro_stream_cipher_core.sv
verif/forro_checker.sv
verif/testbench.sv
